// ===== hdl/rc2_pkg.sv =====
// rc2_pkg: shared types, constants and helper functions for the RC2 cipher engine.
// Used by rc2_ctrl, rc2_dp and rc2_block_cipher; depends on nothing.
`default_nettype none

package rc2_pkg;

	localparam int WORD_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int KIDX_W  = 7;
	localparam int KLEN_W  = 8;
	localparam int EBITS_W = 11;
	localparam int CFG_W   = 11;

	// input beat command codes
	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_EXPAND  = 2'd1,
		CMD_ENCRYPT = 2'd2,
		CMD_DECRYPT = 2'd3
	} rc2_code_t;

	// configuration register indexes
	localparam logic CFG_KEY_LENGTH = 1'b0;
	localparam logic CFG_EFF_BITS   = 1'b1;

	localparam logic [KLEN_W-1:0]  KEY_LENGTH_RST = 8'd16;
	localparam logic [EBITS_W-1:0] EFF_BITS_RST   = 11'd1024;
	localparam logic [KLEN_W-1:0]  KEY_BYTES_MAX  = 8'd128;
	localparam logic [EBITS_W-1:0] EFF_BITS_MAX   = 11'd1024;
	localparam logic [KLEN_W-1:0]  KEY_LAST_BYTE  = 8'd127;

	// subkey counter landmarks
	localparam logic [5:0] J_FIRST_FWD  = 6'd0;
	localparam logic [5:0] J_FIRST_INV  = 6'd63;
	localparam logic [5:0] J_MASH_FWD_A = 6'd19;
	localparam logic [5:0] J_MASH_FWD_B = 6'd43;
	localparam logic [5:0] J_LAST_FWD   = 6'd63;
	localparam logic [5:0] J_MASH_INV_A = 6'd44;
	localparam logic [5:0] J_MASH_INV_B = 6'd20;
	localparam logic [5:0] J_LAST_INV   = 6'd0;

	localparam logic [1:0] M_FIRST_FWD = 2'd0;
	localparam logic [1:0] M_FIRST_INV = 2'd3;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_CAPTURE,
		DP_KEY_RD,
		DP_MIX,
		DP_MASH_RD,
		DP_MASH,
		DP_BYTE_RD,
		DP_PREV,
		DP_EXP1,
		DP_EXP2,
		DP_EXP3,
		DP_OUT
	} rc2_op_t;

	typedef struct packed {
		rc2_op_t     op;
		logic        inv;
		logic [1:0]  idx;
		logic [5:0]  kaddr;
		logic [6:0]  baddr;
		logic [7:0]  mask;
	} rc2_cmd_t;

	typedef struct packed {
		logic out_free;
	} rc2_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MIX,
		ST_MASH_RD,
		ST_MASH_UPD,
		ST_DONE,
		ST_X_INIT,
		ST_X_PREV,
		ST_X1_RD,
		ST_X1_WR,
		ST_X2_RD,
		ST_X2_WR,
		ST_X3_RD,
		ST_X3_WR
	} rc2_state_t;

	localparam logic [7:0] PI_TABLE [0:255] = '{
		8'hd9,8'h78,8'hf9,8'hc4,8'h19,8'hdd,8'hb5,8'hed,8'h28,8'he9,8'hfd,8'h79,8'h4a,8'ha0,8'hd8,8'h9d,
		8'hc6,8'h7e,8'h37,8'h83,8'h2b,8'h76,8'h53,8'h8e,8'h62,8'h4c,8'h64,8'h88,8'h44,8'h8b,8'hfb,8'ha2,
		8'h17,8'h9a,8'h59,8'hf5,8'h87,8'hb3,8'h4f,8'h13,8'h61,8'h45,8'h6d,8'h8d,8'h09,8'h81,8'h7d,8'h32,
		8'hbd,8'h8f,8'h40,8'heb,8'h86,8'hb7,8'h7b,8'h0b,8'hf0,8'h95,8'h21,8'h22,8'h5c,8'h6b,8'h4e,8'h82,
		8'h54,8'hd6,8'h65,8'h93,8'hce,8'h60,8'hb2,8'h1c,8'h73,8'h56,8'hc0,8'h14,8'ha7,8'h8c,8'hf1,8'hdc,
		8'h12,8'h75,8'hca,8'h1f,8'h3b,8'hbe,8'he4,8'hd1,8'h42,8'h3d,8'hd4,8'h30,8'ha3,8'h3c,8'hb6,8'h26,
		8'h6f,8'hbf,8'h0e,8'hda,8'h46,8'h69,8'h07,8'h57,8'h27,8'hf2,8'h1d,8'h9b,8'hbc,8'h94,8'h43,8'h03,
		8'hf8,8'h11,8'hc7,8'hf6,8'h90,8'hef,8'h3e,8'he7,8'h06,8'hc3,8'hd5,8'h2f,8'hc8,8'h66,8'h1e,8'hd7,
		8'h08,8'he8,8'hea,8'hde,8'h80,8'h52,8'hee,8'hf7,8'h84,8'haa,8'h72,8'hac,8'h35,8'h4d,8'h6a,8'h2a,
		8'h96,8'h1a,8'hd2,8'h71,8'h5a,8'h15,8'h49,8'h74,8'h4b,8'h9f,8'hd0,8'h5e,8'h04,8'h18,8'ha4,8'hec,
		8'hc2,8'he0,8'h41,8'h6e,8'h0f,8'h51,8'hcb,8'hcc,8'h24,8'h91,8'haf,8'h50,8'ha1,8'hf4,8'h70,8'h39,
		8'h99,8'h7c,8'h3a,8'h85,8'h23,8'hb8,8'hb4,8'h7a,8'hfc,8'h02,8'h36,8'h5b,8'h25,8'h55,8'h97,8'h31,
		8'h2d,8'h5d,8'hfa,8'h98,8'he3,8'h8a,8'h92,8'hae,8'h05,8'hdf,8'h29,8'h10,8'h67,8'h6c,8'hba,8'hc9,
		8'hd3,8'h00,8'he6,8'hcf,8'he1,8'h9e,8'ha8,8'h2c,8'h63,8'h16,8'h01,8'h3f,8'h58,8'he2,8'h89,8'ha9,
		8'h0d,8'h38,8'h34,8'h1b,8'hab,8'h33,8'hff,8'hb0,8'hbb,8'h48,8'h0c,8'h5f,8'hb9,8'hb1,8'hcd,8'h2e,
		8'hc5,8'hf3,8'hdb,8'h47,8'he5,8'ha5,8'h9c,8'h77,8'h0a,8'ha6,8'h20,8'h68,8'hfe,8'h7f,8'hc1,8'had
	};

	function automatic logic [7:0] pi_sub(input logic [7:0] b);
		return PI_TABLE[b];
	endfunction

	// rotate amounts per word: 1, 2, 3, 5
	function automatic logic [15:0] rot_left(input logic [15:0] v, input logic [1:0] idx);
		logic [15:0] r;
		unique case (idx)
			2'd0: r = {v[14:0], v[15]};
			2'd1: r = {v[13:0], v[15:14]};
			2'd2: r = {v[12:0], v[15:13]};
			2'd3: r = {v[10:0], v[15:11]};
		endcase
		return r;
	endfunction

	function automatic logic [15:0] rot_right(input logic [15:0] v, input logic [1:0] idx);
		logic [15:0] r;
		unique case (idx)
			2'd0: r = {v[0],   v[15:1]};
			2'd1: r = {v[1:0], v[15:2]};
			2'd2: r = {v[2:0], v[15:3]};
			2'd3: r = {v[4:0], v[15:5]};
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/rc2_ram.sv =====
// rc2_ram: generic single write port RAM with one registered read port.
// No dependencies.
`default_nettype none

module rc2_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/rc2_dp.sv =====
// rc2_dp: cipher datapath - block word registers, key table banks, round arithmetic,
// key expansion byte path and output register. Uses rc2_pkg and rc2_ram.
`default_nettype none

module rc2_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire rc2_pkg::rc2_cmd_t               dp_cmd,
	output rc2_pkg::rc2_sts_t                    sts,
	input  wire logic [rc2_pkg::KIDX_W-1:0]      key_index,
	input  wire logic [rc2_pkg::BYTE_W-1:0]      key_byte,
	input  wire logic [rc2_pkg::WORD_W-1:0]      in_word0,
	input  wire logic [rc2_pkg::WORD_W-1:0]      in_word1,
	input  wire logic [rc2_pkg::WORD_W-1:0]      in_word2,
	input  wire logic [rc2_pkg::WORD_W-1:0]      in_word3,
	input  wire logic                            out_stall,
	output logic                                 out_valid,
	output logic [rc2_pkg::WORD_W-1:0]           out_word0,
	output logic [rc2_pkg::WORD_W-1:0]           out_word1,
	output logic [rc2_pkg::WORD_W-1:0]           out_word2,
	output logic [rc2_pkg::WORD_W-1:0]           out_word3
);

	logic [15:0] r0_q, r1_q, r2_q, r3_q;
	logic [15:0] cur, wa, wb, wc, fmix, subkey, new_val;
	logic [7:0]  rd_even, rd_odd, rbyte, exp_val, prev_q, wdata;
	logic        rsel_q;
	logic        we_even, we_odd;
	logic [5:0]  waddr, raddr;
	logic        out_valid_q;
	logic [15:0] ow0_q, ow1_q, ow2_q, ow3_q;

	// word selection around the current index
	always_comb begin
		unique case (dp_cmd.idx)
			2'd0: begin cur = r0_q; wc = r1_q; wb = r2_q; wa = r3_q; end
			2'd1: begin cur = r1_q; wc = r2_q; wb = r3_q; wa = r0_q; end
			2'd2: begin cur = r2_q; wc = r3_q; wb = r0_q; wa = r1_q; end
			2'd3: begin cur = r3_q; wc = r0_q; wb = r1_q; wa = r2_q; end
		endcase
	end

	assign subkey = {rd_odd, rd_even};
	assign fmix   = (wa & wb) | (~wa & wc);

	always_comb begin
		if (dp_cmd.op == rc2_pkg::DP_MASH) begin
			new_val = dp_cmd.inv ? 16'(cur - subkey) : 16'(cur + subkey);
		end else if (dp_cmd.inv) begin
			new_val = 16'(rc2_pkg::rot_right(cur, dp_cmd.idx) - subkey - fmix);
		end else begin
			new_val = rc2_pkg::rot_left(16'(cur + subkey + fmix), dp_cmd.idx);
		end
	end

	always_ff @(posedge clk) begin
		unique case (dp_cmd.op)
			rc2_pkg::DP_CAPTURE: begin
				r0_q <= in_word0;
				r1_q <= in_word1;
				r2_q <= in_word2;
				r3_q <= in_word3;
			end
			rc2_pkg::DP_MIX, rc2_pkg::DP_MASH: begin
				unique case (dp_cmd.idx)
					2'd0: r0_q <= new_val;
					2'd1: r1_q <= new_val;
					2'd2: r2_q <= new_val;
					2'd3: r3_q <= new_val;
				endcase
			end
			default: ;
		endcase
	end

	// key expansion byte path
	assign rbyte = rsel_q ? rd_odd : rd_even;

	always_comb begin
		unique case (dp_cmd.op)
			rc2_pkg::DP_EXP1: exp_val = rc2_pkg::pi_sub(8'(prev_q + rbyte));
			rc2_pkg::DP_EXP2: exp_val = rc2_pkg::pi_sub(rbyte & dp_cmd.mask);
			default:          exp_val = rc2_pkg::pi_sub(prev_q ^ rbyte);
		endcase
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.op == rc2_pkg::DP_BYTE_RD) begin
			rsel_q <= dp_cmd.baddr[0];
		end
		unique case (dp_cmd.op)
			rc2_pkg::DP_PREV:                                    prev_q <= rbyte;
			rc2_pkg::DP_EXP1, rc2_pkg::DP_EXP2, rc2_pkg::DP_EXP3: prev_q <= exp_val;
			default: ;
		endcase
	end

	// key table write and read ports
	always_comb begin
		we_even = 1'b0;
		we_odd  = 1'b0;
		waddr   = dp_cmd.baddr[6:1];
		wdata   = exp_val;
		unique case (dp_cmd.op)
			rc2_pkg::DP_LOAD: begin
				we_even = ~key_index[0];
				we_odd  = key_index[0];
				waddr   = key_index[6:1];
				wdata   = key_byte;
			end
			rc2_pkg::DP_EXP1, rc2_pkg::DP_EXP2, rc2_pkg::DP_EXP3: begin
				we_even = ~dp_cmd.baddr[0];
				we_odd  = dp_cmd.baddr[0];
			end
			default: ;
		endcase
	end

	always_comb begin
		unique case (dp_cmd.op)
			rc2_pkg::DP_MASH_RD: raddr = wa[5:0];
			rc2_pkg::DP_BYTE_RD: raddr = dp_cmd.baddr[6:1];
			default:             raddr = dp_cmd.kaddr;
		endcase
	end

	rc2_ram #(.WIDTH(8), .DEPTH(64)) u_key_even (
		.clk   (clk),
		.we    (we_even),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_even)
	);

	rc2_ram #(.WIDTH(8), .DEPTH(64)) u_key_odd (
		.clk   (clk),
		.we    (we_odd),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_odd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.op == rc2_pkg::DP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.op == rc2_pkg::DP_OUT) begin
			ow0_q <= r0_q;
			ow1_q <= r1_q;
			ow2_q <= r2_q;
			ow3_q <= r3_q;
		end
	end

	assign sts.out_free = ~out_valid_q | ~out_stall;
	assign out_valid    = out_valid_q;
	assign out_word0    = ow0_q;
	assign out_word1    = ow1_q;
	assign out_word2    = ow2_q;
	assign out_word3    = ow3_q;

endmodule

`default_nettype wire

// ===== hdl/rc2_ctrl.sv =====
// rc2_ctrl: sequencer for key load, key expansion and the cipher rounds, plus the
// configuration registers. Uses rc2_pkg; drives rc2_dp through rc2_cmd_t.
`default_nettype none

module rc2_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   cmd,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [rc2_pkg::CFG_W-1:0]    cfg_data,
	input  wire rc2_pkg::rc2_sts_t            sts,
	output rc2_pkg::rc2_cmd_t                 dp_cmd
);

	rc2_pkg::rc2_state_t state_q, state_nxt;

	logic [rc2_pkg::KLEN_W-1:0]  key_length_q;
	logic [rc2_pkg::EBITS_W-1:0] eff_bits_q;
	logic [5:0]  j_q, j_nxt;
	logic [1:0]  m_q;
	logic [7:0]  i_q;
	logic        inv_q;
	logic        accept;
	logic        mix_last, mix_mash, m_last;
	logic [7:0]  t1, t8;
	logic [10:0] bits_c;
	logic [11:0] bits_p7;
	logic [2:0]  mask_sh;
	logic [7:0]  mask;

	// clamped expansion parameters
	always_comb begin
		if (key_length_q == '0) begin
			t1 = 8'd1;
		end else if (key_length_q > rc2_pkg::KEY_BYTES_MAX) begin
			t1 = rc2_pkg::KEY_BYTES_MAX;
		end else begin
			t1 = key_length_q;
		end
		if (eff_bits_q == '0) begin
			bits_c = 11'd1;
		end else if (eff_bits_q > rc2_pkg::EFF_BITS_MAX) begin
			bits_c = rc2_pkg::EFF_BITS_MAX;
		end else begin
			bits_c = eff_bits_q;
		end
	end

	assign bits_p7 = {1'b0, bits_c} + 12'd7;
	assign t8      = bits_p7[10:3];
	assign mask_sh = 3'(3'd0 - bits_c[2:0]);
	assign mask    = 8'hFF >> mask_sh;

	assign accept   = in_valid & (state_q == rc2_pkg::ST_IDLE);
	assign in_stall = (state_q != rc2_pkg::ST_IDLE);

	assign j_nxt    = inv_q ? 6'(j_q - 6'd1) : 6'(j_q + 6'd1);
	assign mix_last = inv_q ? (j_q == rc2_pkg::J_LAST_INV) : (j_q == rc2_pkg::J_LAST_FWD);
	assign mix_mash = inv_q ?
		((j_q == rc2_pkg::J_MASH_INV_A) || (j_q == rc2_pkg::J_MASH_INV_B)) :
		((j_q == rc2_pkg::J_MASH_FWD_A) || (j_q == rc2_pkg::J_MASH_FWD_B));
	assign m_last   = inv_q ? (m_q == rc2_pkg::M_FIRST_FWD) : (m_q == rc2_pkg::M_FIRST_INV);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rc2_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (rc2_pkg::rc2_code_t'(cmd))
						rc2_pkg::CMD_LOAD:    state_nxt = rc2_pkg::ST_IDLE;
						rc2_pkg::CMD_EXPAND:  state_nxt = rc2_pkg::ST_X_INIT;
						rc2_pkg::CMD_ENCRYPT,
						rc2_pkg::CMD_DECRYPT: state_nxt = rc2_pkg::ST_FETCH;
					endcase
				end
			end
			rc2_pkg::ST_FETCH: state_nxt = rc2_pkg::ST_MIX;
			rc2_pkg::ST_MIX: begin
				if (mix_last) begin
					state_nxt = rc2_pkg::ST_DONE;
				end else if (mix_mash) begin
					state_nxt = rc2_pkg::ST_MASH_RD;
				end
			end
			rc2_pkg::ST_MASH_RD: state_nxt = rc2_pkg::ST_MASH_UPD;
			rc2_pkg::ST_MASH_UPD: begin
				state_nxt = m_last ? rc2_pkg::ST_FETCH : rc2_pkg::ST_MASH_RD;
			end
			rc2_pkg::ST_DONE: begin
				if (sts.out_free) begin
					state_nxt = rc2_pkg::ST_IDLE;
				end
			end
			rc2_pkg::ST_X_INIT: state_nxt = rc2_pkg::ST_X_PREV;
			rc2_pkg::ST_X_PREV: begin
				state_nxt = (t1 == rc2_pkg::KEY_BYTES_MAX) ? rc2_pkg::ST_X2_RD : rc2_pkg::ST_X1_RD;
			end
			rc2_pkg::ST_X1_RD: state_nxt = rc2_pkg::ST_X1_WR;
			rc2_pkg::ST_X1_WR: begin
				state_nxt = (i_q == rc2_pkg::KEY_LAST_BYTE) ? rc2_pkg::ST_X2_RD : rc2_pkg::ST_X1_RD;
			end
			rc2_pkg::ST_X2_RD: state_nxt = rc2_pkg::ST_X2_WR;
			rc2_pkg::ST_X2_WR: begin
				state_nxt = (t8 == rc2_pkg::KEY_BYTES_MAX) ? rc2_pkg::ST_IDLE : rc2_pkg::ST_X3_RD;
			end
			rc2_pkg::ST_X3_RD: state_nxt = rc2_pkg::ST_X3_WR;
			rc2_pkg::ST_X3_WR: begin
				state_nxt = (i_q == '0) ? rc2_pkg::ST_IDLE : rc2_pkg::ST_X3_RD;
			end
			default: state_nxt = rc2_pkg::ST_IDLE;
		endcase
	end

	// datapath command
	always_comb begin
		dp_cmd       = '0;
		dp_cmd.op    = rc2_pkg::DP_NOP;
		dp_cmd.inv   = inv_q;
		dp_cmd.kaddr = j_q;
		dp_cmd.mask  = mask;
		unique case (state_q)
			rc2_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (rc2_pkg::rc2_code_t'(cmd))
						rc2_pkg::CMD_LOAD:    dp_cmd.op = rc2_pkg::DP_LOAD;
						rc2_pkg::CMD_EXPAND:  dp_cmd.op = rc2_pkg::DP_NOP;
						rc2_pkg::CMD_ENCRYPT,
						rc2_pkg::CMD_DECRYPT: dp_cmd.op = rc2_pkg::DP_CAPTURE;
					endcase
				end
			end
			rc2_pkg::ST_FETCH: dp_cmd.op = rc2_pkg::DP_KEY_RD;
			rc2_pkg::ST_MIX: begin
				dp_cmd.op    = rc2_pkg::DP_MIX;
				dp_cmd.idx   = j_q[1:0];
				dp_cmd.kaddr = j_nxt;
			end
			rc2_pkg::ST_MASH_RD: begin
				dp_cmd.op  = rc2_pkg::DP_MASH_RD;
				dp_cmd.idx = m_q;
			end
			rc2_pkg::ST_MASH_UPD: begin
				dp_cmd.op  = rc2_pkg::DP_MASH;
				dp_cmd.idx = m_q;
			end
			rc2_pkg::ST_DONE: begin
				if (sts.out_free) begin
					dp_cmd.op = rc2_pkg::DP_OUT;
				end
			end
			rc2_pkg::ST_X_INIT: begin
				dp_cmd.op    = rc2_pkg::DP_BYTE_RD;
				dp_cmd.baddr = 7'(t1 - 8'd1);
			end
			rc2_pkg::ST_X_PREV: dp_cmd.op = rc2_pkg::DP_PREV;
			rc2_pkg::ST_X1_RD: begin
				dp_cmd.op    = rc2_pkg::DP_BYTE_RD;
				dp_cmd.baddr = 7'(i_q - t1);
			end
			rc2_pkg::ST_X1_WR: begin
				dp_cmd.op    = rc2_pkg::DP_EXP1;
				dp_cmd.baddr = i_q[6:0];
			end
			rc2_pkg::ST_X2_RD: begin
				dp_cmd.op    = rc2_pkg::DP_BYTE_RD;
				dp_cmd.baddr = 7'(rc2_pkg::KEY_BYTES_MAX - t8);
			end
			rc2_pkg::ST_X2_WR: begin
				dp_cmd.op    = rc2_pkg::DP_EXP2;
				dp_cmd.baddr = 7'(rc2_pkg::KEY_BYTES_MAX - t8);
			end
			rc2_pkg::ST_X3_RD: begin
				dp_cmd.op    = rc2_pkg::DP_BYTE_RD;
				dp_cmd.baddr = 7'(i_q + t8);
			end
			rc2_pkg::ST_X3_WR: begin
				dp_cmd.op    = rc2_pkg::DP_EXP3;
				dp_cmd.baddr = i_q[6:0];
			end
			default: dp_cmd.op = rc2_pkg::DP_NOP;
		endcase
	end

	// state, counters, configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rc2_pkg::ST_IDLE;
			key_length_q <= rc2_pkg::KEY_LENGTH_RST;
			eff_bits_q   <= rc2_pkg::EFF_BITS_RST;
			j_q          <= '0;
			m_q          <= '0;
			i_q          <= '0;
			inv_q        <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				unique case (cfg_index)
					rc2_pkg::CFG_KEY_LENGTH: key_length_q <= cfg_data[rc2_pkg::KLEN_W-1:0];
					rc2_pkg::CFG_EFF_BITS:   eff_bits_q   <= cfg_data[rc2_pkg::EBITS_W-1:0];
				endcase
			end
			unique case (state_q)
				rc2_pkg::ST_IDLE: begin
					if (accept) begin
						inv_q <= (rc2_pkg::rc2_code_t'(cmd) == rc2_pkg::CMD_DECRYPT);
						j_q   <= (rc2_pkg::rc2_code_t'(cmd) == rc2_pkg::CMD_DECRYPT) ?
							rc2_pkg::J_FIRST_INV : rc2_pkg::J_FIRST_FWD;
					end
				end
				rc2_pkg::ST_MIX: begin
					j_q <= j_nxt;
					if (mix_mash) begin
						m_q <= inv_q ? rc2_pkg::M_FIRST_INV : rc2_pkg::M_FIRST_FWD;
					end
				end
				rc2_pkg::ST_MASH_UPD: m_q <= inv_q ? 2'(m_q - 2'd1) : 2'(m_q + 2'd1);
				rc2_pkg::ST_X_PREV:   i_q <= t1;
				rc2_pkg::ST_X1_WR:    i_q <= 8'(i_q + 8'd1);
				rc2_pkg::ST_X2_WR:    i_q <= 8'(rc2_pkg::KEY_LAST_BYTE - t8);
				rc2_pkg::ST_X3_WR:    i_q <= 8'(i_q - 8'd1);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rc2_block_cipher.sv =====
// rc2_block_cipher: top level of the RC2 engine (key load, key expansion, encrypt, decrypt).
// Instantiates rc2_ctrl and rc2_dp; types and constants from rc2_pkg.
//
//   channel   handshake              payload
//   input     in_valid / in_stall    cmd, key_index, key_byte, in_word0..in_word3
//   output    out_valid / out_stall  out_word0..out_word3
//   config    cfg_we                 cfg_index, cfg_data
//
// Load key byte: written as the beat is taken. Encrypt/decrypt: the mixing steps (64) run
// one per cycle between the mashing steps, each mashing step a read state and an update
// state on the single key table read port. Expand: a read and a write state per byte made.
// Reset clears the sequencer and sets the registers; the key table is not cleared.
// A new beat is taken while a result waits; a stalled result blocks the next one and new beats.
`default_nettype none

module rc2_block_cipher (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [rc2_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    cmd,
	input  wire logic [rc2_pkg::KIDX_W-1:0]    key_index,
	input  wire logic [rc2_pkg::BYTE_W-1:0]    key_byte,
	input  wire logic [rc2_pkg::WORD_W-1:0]    in_word0,
	input  wire logic [rc2_pkg::WORD_W-1:0]    in_word1,
	input  wire logic [rc2_pkg::WORD_W-1:0]    in_word2,
	input  wire logic [rc2_pkg::WORD_W-1:0]    in_word3,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [rc2_pkg::WORD_W-1:0]         out_word0,
	output logic [rc2_pkg::WORD_W-1:0]         out_word1,
	output logic [rc2_pkg::WORD_W-1:0]         out_word2,
	output logic [rc2_pkg::WORD_W-1:0]         out_word3
);

	rc2_pkg::rc2_cmd_t dp_cmd;
	rc2_pkg::rc2_sts_t sts;

	rc2_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sts       (sts),
		.dp_cmd    (dp_cmd)
	);

	rc2_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_cmd    (dp_cmd),
		.sts       (sts),
		.key_index (key_index),
		.key_byte  (key_byte),
		.in_word0  (in_word0),
		.in_word1  (in_word1),
		.in_word2  (in_word2),
		.in_word3  (in_word3),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_word0 (out_word0),
		.out_word1 (out_word1),
		.out_word2 (out_word2),
		.out_word3 (out_word3)
	);

endmodule

`default_nettype wire

// ===== tb/rc2_block_cipher_test.sv =====
// rc2_block_cipher_test: self-checking bench for the RC2 engine. A local key schedule and
// cipher predictor checks every result block; stimulus is bursty, output stalls are random.
// Depends on rc2_pkg (command codes, register indexes, widths) and rc2_block_cipher.

module rc2_block_cipher_test;

	localparam int WORD_W  = rc2_pkg::WORD_W;
	localparam int KIDX_W  = rc2_pkg::KIDX_W;
	localparam int BYTE_W  = rc2_pkg::BYTE_W;
	localparam int KLEN_W  = rc2_pkg::KLEN_W;
	localparam int EBITS_W = rc2_pkg::EBITS_W;
	localparam int CFG_W   = rc2_pkg::CFG_W;

	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 7;
	localparam int SETTLE_CYCLES  = 600;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_ITEMS    = 80;
	localparam int FIXED_PHASES   = 7;
	localparam int TOTAL_PHASES   = 14;
	localparam int HOLD_CYCLES    = 700;
	localparam int HOLD_SPACING   = 30000;
	localparam int MAX_REPORTS    = 10;

	localparam int FIXED_KL [FIXED_PHASES] = '{1, 128, 0, 255, 16, 127, 40};
	localparam int FIXED_EB [FIXED_PHASES] = '{1, 1024, 0, 2047, 8, 9, 513};

	localparam int ROT_AMT [4] = '{1, 2, 3, 5};

	localparam logic [7:0] PI_PERM [0:255] = '{
		8'hd9,8'h78,8'hf9,8'hc4,8'h19,8'hdd,8'hb5,8'hed,8'h28,8'he9,8'hfd,8'h79,8'h4a,8'ha0,8'hd8,8'h9d,
		8'hc6,8'h7e,8'h37,8'h83,8'h2b,8'h76,8'h53,8'h8e,8'h62,8'h4c,8'h64,8'h88,8'h44,8'h8b,8'hfb,8'ha2,
		8'h17,8'h9a,8'h59,8'hf5,8'h87,8'hb3,8'h4f,8'h13,8'h61,8'h45,8'h6d,8'h8d,8'h09,8'h81,8'h7d,8'h32,
		8'hbd,8'h8f,8'h40,8'heb,8'h86,8'hb7,8'h7b,8'h0b,8'hf0,8'h95,8'h21,8'h22,8'h5c,8'h6b,8'h4e,8'h82,
		8'h54,8'hd6,8'h65,8'h93,8'hce,8'h60,8'hb2,8'h1c,8'h73,8'h56,8'hc0,8'h14,8'ha7,8'h8c,8'hf1,8'hdc,
		8'h12,8'h75,8'hca,8'h1f,8'h3b,8'hbe,8'he4,8'hd1,8'h42,8'h3d,8'hd4,8'h30,8'ha3,8'h3c,8'hb6,8'h26,
		8'h6f,8'hbf,8'h0e,8'hda,8'h46,8'h69,8'h07,8'h57,8'h27,8'hf2,8'h1d,8'h9b,8'hbc,8'h94,8'h43,8'h03,
		8'hf8,8'h11,8'hc7,8'hf6,8'h90,8'hef,8'h3e,8'he7,8'h06,8'hc3,8'hd5,8'h2f,8'hc8,8'h66,8'h1e,8'hd7,
		8'h08,8'he8,8'hea,8'hde,8'h80,8'h52,8'hee,8'hf7,8'h84,8'haa,8'h72,8'hac,8'h35,8'h4d,8'h6a,8'h2a,
		8'h96,8'h1a,8'hd2,8'h71,8'h5a,8'h15,8'h49,8'h74,8'h4b,8'h9f,8'hd0,8'h5e,8'h04,8'h18,8'ha4,8'hec,
		8'hc2,8'he0,8'h41,8'h6e,8'h0f,8'h51,8'hcb,8'hcc,8'h24,8'h91,8'haf,8'h50,8'ha1,8'hf4,8'h70,8'h39,
		8'h99,8'h7c,8'h3a,8'h85,8'h23,8'hb8,8'hb4,8'h7a,8'hfc,8'h02,8'h36,8'h5b,8'h25,8'h55,8'h97,8'h31,
		8'h2d,8'h5d,8'hfa,8'h98,8'he3,8'h8a,8'h92,8'hae,8'h05,8'hdf,8'h29,8'h10,8'h67,8'h6c,8'hba,8'hc9,
		8'hd3,8'h00,8'he6,8'hcf,8'he1,8'h9e,8'ha8,8'h2c,8'h63,8'h16,8'h01,8'h3f,8'h58,8'he2,8'h89,8'ha9,
		8'h0d,8'h38,8'h34,8'h1b,8'hab,8'h33,8'hff,8'hb0,8'hbb,8'h48,8'h0c,8'h5f,8'hb9,8'hb1,8'hcd,8'h2e,
		8'hc5,8'hf3,8'hdb,8'h47,8'he5,8'ha5,8'h9c,8'h77,8'h0a,8'ha6,8'h20,8'h68,8'hfe,8'h7f,8'hc1,8'had
	};

	typedef logic [3:0][WORD_W-1:0] block_t;

	typedef struct {
		rc2_pkg::rc2_code_t  op;
		logic [KIDX_W-1:0]   idx;
		logic [BYTE_W-1:0]   kbyte;
		block_t              data;
	} cipher_req_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic                 cfg_index = rc2_pkg::CFG_KEY_LENGTH;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [1:0]           cmd       = rc2_pkg::CMD_LOAD;
	logic [KIDX_W-1:0]    key_index = '0;
	logic [BYTE_W-1:0]    key_byte  = '0;
	logic [WORD_W-1:0]    in_word0  = '0;
	logic [WORD_W-1:0]    in_word1  = '0;
	logic [WORD_W-1:0]    in_word2  = '0;
	logic [WORD_W-1:0]    in_word3  = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [WORD_W-1:0]    out_word0;
	logic [WORD_W-1:0]    out_word1;
	logic [WORD_W-1:0]    out_word2;
	logic [WORD_W-1:0]    out_word3;

	// predictor state
	logic [7:0]           key_tab [0:127];
	logic [KLEN_W-1:0]    key_len_reg;
	logic [EBITS_W-1:0]   eff_bits_reg;

	cipher_req_t          req_queue [$];
	block_t               expected_blocks [$];
	cipher_req_t          next_req;
	block_t               rx_got;
	block_t               rx_want;

	int                   reqs_outstanding = 0;
	int                   op_count [4] = '{default: 0};
	int                   blocks_checked = 0;
	int                   error_count = 0;
	int                   settings_applied = 0;
	int                   stuck_cycles = 0;
	logic                 in_accepted = 1'b0;
	int                   burst_left = 0;
	int                   gap_left = 0;
	int                   rx_cycle = 0;
	int                   hold_left = 0;
	int                   next_hold_at = 3000;
	int                   mode_left = 0;
	rx_mode_t             rx_mode = RX_FREE;

	rc2_block_cipher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.key_index (key_index),
		.key_byte  (key_byte),
		.in_word0  (in_word0),
		.in_word1  (in_word1),
		.in_word2  (in_word2),
		.in_word3  (in_word3),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word0 (out_word0),
		.out_word1 (out_word1),
		.out_word2 (out_word2),
		.out_word3 (out_word3)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic logic [15:0] subkey_of(input logic [5:0] j);
		return {key_tab[{j, 1'b1}], key_tab[{j, 1'b0}]};
	endfunction

	function automatic logic [15:0] rotl16(input logic [15:0] v, input int s);
		return (v << s) | (v >> (16 - s));
	endfunction

	function automatic logic [15:0] rotr16(input logic [15:0] v, input int s);
		return (v >> s) | (v << (16 - s));
	endfunction

	function automatic void expand_table();
		int t1, bits, t8;
		logic [7:0] mask, sum;
		t1 = key_len_reg;
		if (t1 < 1) t1 = 1;
		if (t1 > 128) t1 = 128;
		bits = eff_bits_reg;
		if (bits < 1) bits = 1;
		if (bits > 1024) bits = 1024;
		t8 = (bits + 7) / 8;
		mask = 8'((1 << (8 + bits - 8 * t8)) - 1);
		for (int i = t1; i < 128; i++) begin
			sum = key_tab[i - 1] + key_tab[i - t1];
			key_tab[i] = PI_PERM[sum];
		end
		key_tab[128 - t8] = PI_PERM[key_tab[128 - t8] & mask];
		for (int i = 127 - t8; i >= 0; i--)
			key_tab[i] = PI_PERM[key_tab[i + 1] ^ key_tab[i + t8]];
	endfunction

	function automatic block_t encrypt_block(input block_t b);
		block_t r;
		logic [5:0] j;
		logic [15:0] a, p, q;
		r = b;
		j = '0;
		for (int rnd = 0; rnd < 16; rnd++) begin
			if (rnd == 5 || rnd == 11)
				for (int i = 0; i < 4; i++)
					r[i] = r[i] + subkey_of(r[(i + 3) % 4][5:0]);
			for (int i = 0; i < 4; i++) begin
				a = r[(i + 3) % 4];
				p = r[(i + 2) % 4];
				q = r[(i + 1) % 4];
				r[i] = rotl16(r[i] + subkey_of(j) + (a & p) + (~a & q), ROT_AMT[i]);
				j++;
			end
		end
		return r;
	endfunction

	function automatic block_t decrypt_block(input block_t b);
		block_t r;
		logic [5:0] j;
		logic [15:0] a, p, q;
		r = b;
		j = 6'd63;
		for (int rnd = 0; rnd < 16; rnd++) begin
			if (rnd == 5 || rnd == 11)
				for (int i = 3; i >= 0; i--)
					r[i] = r[i] - subkey_of(r[(i + 3) % 4][5:0]);
			for (int i = 3; i >= 0; i--) begin
				r[i] = rotr16(r[i], ROT_AMT[i]);
				a = r[(i + 3) % 4];
				p = r[(i + 2) % 4];
				q = r[(i + 1) % 4];
				r[i] = r[i] - subkey_of(j) - (a & p) - (~a & q);
				j--;
			end
		end
		return r;
	endfunction

	function automatic block_t rand_block();
		return {$urandom, $urandom};
	endfunction

	function automatic void queue_req(input rc2_pkg::rc2_code_t op,
			input logic [KIDX_W-1:0] idx, input logic [BYTE_W-1:0] kb, input block_t blk);
		cipher_req_t req;
		req.op = op;
		req.idx = idx;
		req.kbyte = kb;
		req.data = blk;
		req_queue.push_back(req);
		reqs_outstanding++;
	endfunction

	function automatic void log_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("ERROR: %s", msg);
	endfunction

	// mostly cipher beats; now and then a clean rekey (bytes below key length, then expand)
	task automatic queue_random(input int n);
		int made, pick, t1;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				t1 = (key_len_reg == 0) ? 1 : (key_len_reg > 128) ? 128 : key_len_reg;
				for (int i = 0; i < t1; i++)
					queue_req(rc2_pkg::CMD_LOAD, KIDX_W'(i), BYTE_W'($urandom), rand_block());
				queue_req(rc2_pkg::CMD_EXPAND, KIDX_W'($urandom), BYTE_W'($urandom),
					rand_block());
				made += t1 + 1;
			end else begin
				if (pick < 16)
					queue_req(rc2_pkg::CMD_LOAD, KIDX_W'($urandom), BYTE_W'($urandom),
						rand_block());
				else if (pick < 19)
					queue_req(rc2_pkg::CMD_EXPAND, KIDX_W'($urandom), BYTE_W'($urandom),
						rand_block());
				else if (pick < 59)
					queue_req(rc2_pkg::CMD_ENCRYPT, KIDX_W'($urandom), BYTE_W'($urandom),
						rand_block());
				else
					queue_req(rc2_pkg::CMD_DECRYPT, KIDX_W'($urandom), BYTE_W'($urandom),
						rand_block());
				made++;
			end
		end
	endtask

	task automatic write_reg(input logic idx, input int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		if (idx == rc2_pkg::CFG_KEY_LENGTH)
			key_len_reg = KLEN_W'(value);
		else
			eff_bits_reg = EBITS_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// expand gives no result, so allow for one still running after the last block
	task automatic drain();
		while (reqs_outstanding != 0 || expected_blocks.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// sender: bursts of beats with random gaps
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_accepted)) begin
			if (burst_left == 0 && gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (req_queue.size() != 0) begin
				if (burst_left == 0)
					burst_left = $urandom_range(1, 24);
				next_req = req_queue.pop_front();
				cmd <= next_req.op;
				key_index <= next_req.idx;
				key_byte <= next_req.kbyte;
				in_word0 <= next_req.data[0];
				in_word1 <= next_req.data[1];
				in_word2 <= next_req.data[2];
				in_word3 <= next_req.data[3];
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// input side: every accepted beat updates the predictor
	always @(posedge clk) begin
		in_accepted <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			reqs_outstanding--;
			op_count[cmd]++;
			case (rc2_pkg::rc2_code_t'(cmd))
				rc2_pkg::CMD_LOAD:    key_tab[key_index] = key_byte;
				rc2_pkg::CMD_EXPAND:  expand_table();
				rc2_pkg::CMD_ENCRYPT: expected_blocks.push_back(
					encrypt_block({in_word3, in_word2, in_word1, in_word0}));
				rc2_pkg::CMD_DECRYPT: expected_blocks.push_back(
					decrypt_block({in_word3, in_word2, in_word1, in_word0}));
			endcase
		end
	end

	// receiver: stall pattern of its own, plus a long hold-off to back the engine up
	always @(negedge clk) begin
		rx_cycle++;
		if (hold_left == 0 && rx_cycle >= next_hold_at && req_queue.size() > 16) begin
			hold_left = HOLD_CYCLES;
			next_hold_at = rx_cycle + HOLD_SPACING;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(40, 400);
			end
			mode_left--;
			case (rx_mode)
				RX_FREE:     out_stall <= 1'b0;
				RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
				RX_PERIODIC: out_stall <= (rx_cycle % 7 < 3);
			endcase
		end
	end

	// output side: compare each result beat with the oldest expected block
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			rx_got = {out_word3, out_word2, out_word1, out_word0};
			if (expected_blocks.size() == 0) begin
				log_error($sformatf("result %h with no block expected", rx_got));
			end else begin
				rx_want = expected_blocks.pop_front();
				for (int i = 0; i < 4; i++)
					if (rx_got[i] !== rx_want[i])
						log_error($sformatf("block %0d out_word%0d: expected %h, got %h",
							blocks_checked, i, rx_want[i], rx_got[i]));
				blocks_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d requests and %0d blocks outstanding",
				stuck_cycles, reqs_outstanding, expected_blocks.size());
			$display("rc2_block_cipher_test NOT OK");
			$finish;
		end
	end

	initial begin
		int kl, eb;
		key_len_reg = 8'd16;
		eff_bits_reg = 11'd1024;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// reset key length: load bytes 0..15 then expand, which defines the whole table
		for (int i = 0; i < 16; i++)
			queue_req(rc2_pkg::CMD_LOAD, KIDX_W'(i),
				(i == 0) ? 8'h00 : (i == 1) ? 8'hff : BYTE_W'($urandom), rand_block());
		queue_req(rc2_pkg::CMD_EXPAND, '1, '1, '1);
		queue_req(rc2_pkg::CMD_ENCRYPT, '0, '0, '0);
		queue_req(rc2_pkg::CMD_ENCRYPT, '1, '1, '1);
		queue_req(rc2_pkg::CMD_DECRYPT, '0, '0, '0);
		queue_req(rc2_pkg::CMD_DECRYPT, '1, '1, '1);
		queue_req(rc2_pkg::CMD_ENCRYPT, '0, '0, {16'h8000, 16'h0001, 16'h00ff, 16'hff00});
		// load over an expanded table, cipher with it, then expand again
		queue_req(rc2_pkg::CMD_LOAD, 7'd127, 8'hff, '1);
		queue_req(rc2_pkg::CMD_ENCRYPT, '0, '0, rand_block());
		queue_req(rc2_pkg::CMD_EXPAND, '0, '0, '0);
		queue_req(rc2_pkg::CMD_DECRYPT, '0, '0, rand_block());
		drain();

		for (int ph = 0; ph < TOTAL_PHASES; ph++) begin
			if (ph < FIXED_PHASES) begin
				kl = FIXED_KL[ph];
				eb = FIXED_EB[ph];
			end else begin
				kl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
					$urandom_range(1, 128);
				eb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) :
					$urandom_range(1, 1024);
			end
			write_reg(rc2_pkg::CFG_KEY_LENGTH, kl);
			write_reg(rc2_pkg::CFG_EFF_BITS, eb);
			settings_applied++;
			queue_req(rc2_pkg::CMD_EXPAND, KIDX_W'($urandom), BYTE_W'($urandom), rand_block());
			queue_random(PHASE_ITEMS);
			drain();
		end

		$display("covered %0d key loads, %0d expansions, %0d encryptions, %0d decryptions",
			op_count[rc2_pkg::CMD_LOAD], op_count[rc2_pkg::CMD_EXPAND],
			op_count[rc2_pkg::CMD_ENCRYPT], op_count[rc2_pkg::CMD_DECRYPT]);
		$display("over %0d register settings; %0d result blocks checked, %0d mismatches",
			settings_applied + 1, blocks_checked, error_count);
		if (error_count == 0 && expected_blocks.size() == 0)
			$display("rc2_block_cipher_test OK");
		else
			$display("rc2_block_cipher_test NOT OK");
		$finish;
	end

endmodule
